[hdl/iecho_pkg.sv]
// Shared constants, types and checksum helpers for the ICMP echo responder.
`default_nettype none
package iecho_pkg;

    localparam int BUF_BYTES = 64;
    localparam int PAD_BYTES = 32;
    localparam int PING_LEN  = 8 + PAD_BYTES;
    localparam int EMIT_MAX  = (BUF_BYTES > PING_LEN) ? BUF_BYTES : PING_LEN;

    localparam int ADDR_W = $clog2(BUF_BYTES);
    localparam int CNT_W  = $clog2(BUF_BYTES + 2);
    localparam int IDX_W  = $clog2(EMIT_MAX + 2);
    localparam int LEN_W  = 7;

    // request codes
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_PING = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_REPLY   = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_RTT     = 2'd2;

    // ICMP message types
    localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
    localparam logic [7:0] TYPE_ECHO_REQ   = 8'd8;

    localparam logic [7:0]  PAD_FILL = 8'hA5;
    localparam logic [15:0] SUM_GOOD = 16'hFFFF;

    // header byte positions
    localparam int POS_TYPE    = 0;
    localparam int POS_CODE    = 1;
    localparam int POS_CSUM_HI = 2;
    localparam int POS_CSUM_LO = 3;
    localparam int POS_ID_HI   = 4;
    localparam int POS_ID_LO   = 5;
    localparam int POS_SEQ_HI  = 6;
    localparam int POS_SEQ_LO  = 7;
    localparam int MIN_LEN     = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FINISH,
        ST_EMIT
    } tx_state_t;

    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic             too_long;
        logic             msg_ok;
        logic [7:0]       msg_type;
        logic [15:0]      msg_id;
        logic [15:0]      msg_seq;
        logic [15:0]      reply_csum;
    } rx_status_t;

    // ones-complement fold of a sum of a few 16-bit words
    function automatic logic [15:0] fold16(input logic [17:0] x);
        logic [16:0] t;
        t = 17'(x[15:0]) + 17'(x[17:16]);
        return t[15:0] + 16'(t[16]);
    endfunction

    function automatic logic [15:0] pad_sum();
        logic [15:0] s;
        s = '0;
        for (int i = 0; i < PAD_BYTES / 2; i++) begin
            s = fold16(18'(s) + 18'({PAD_FILL, PAD_FILL}));
        end
        if ((PAD_BYTES % 2) != 0) begin
            s = fold16(18'(s) + 18'({PAD_FILL, 8'h00}));
        end
        return s;
    endfunction

    localparam logic [15:0] PAD_SUM = pad_sum();

endpackage
`default_nettype wire

[hdl/iecho_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module iecho_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[hdl/iecho_rx.sv]
// Receive side: byte count, running checksums, header capture and buffer writes.
`default_nettype none
module iecho_rx
    import iecho_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_en,
    input  wire logic [7:0]        data_byte,
    input  wire logic              clear,
    output logic                   wr_en,
    output logic      [ADDR_W-1:0] wr_addr,
    output logic      [7:0]        wr_data,
    output rx_status_t             status
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             too_long_reg, too_long_next;
    logic [15:0]      sum_reg, sum_next;
    logic [15:0]      rsum_reg, rsum_next;
    logic             odd_reg, odd_next;
    logic [7:0]       high_reg, high_next;
    logic [7:0]       type_reg, type_next;
    logic [15:0]      id_reg, id_next;
    logic [15:0]      seq_reg, seq_next;

    logic [15:0] word;
    logic [15:0] rword;
    logic [15:0] tail;
    logic [15:0] s_fin;
    logic [15:0] r_fin;

    assign word = {high_reg, data_byte};

    // reply checksum: type byte reads as zero, checksum word drops out
    always_comb
    begin
        if (cnt_reg == CNT_W'(POS_CODE))
            rword = {8'h00, data_byte};
        else if (cnt_reg == CNT_W'(POS_CSUM_LO))
            rword = 16'h0000;
        else
            rword = word;
    end

    assign wr_en   = byte_en && (cnt_reg < CNT_W'(BUF_BYTES));
    assign wr_addr = cnt_reg[ADDR_W-1:0];
    assign wr_data = data_byte;

    always_comb
    begin
        cnt_next      = cnt_reg;
        too_long_next = too_long_reg;
        sum_next      = sum_reg;
        rsum_next     = rsum_reg;
        odd_next      = odd_reg;
        high_next     = high_reg;
        type_next     = type_reg;
        id_next       = id_reg;
        seq_next      = seq_reg;
        if (clear)
        begin
            cnt_next      = '0;
            too_long_next = 1'b0;
            sum_next      = '0;
            rsum_next     = '0;
            odd_next      = 1'b0;
            high_next     = '0;
        end
        else if (byte_en)
        begin
            if (cnt_reg < CNT_W'(BUF_BYTES))
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            else
            begin
                too_long_next = 1'b1;
                cnt_next      = CNT_W'(BUF_BYTES + 1);
            end
            if (cnt_reg == CNT_W'(POS_TYPE))   type_next      = data_byte;
            if (cnt_reg == CNT_W'(POS_ID_HI))  id_next[15:8]  = data_byte;
            if (cnt_reg == CNT_W'(POS_ID_LO))  id_next[7:0]   = data_byte;
            if (cnt_reg == CNT_W'(POS_SEQ_HI)) seq_next[15:8] = data_byte;
            if (cnt_reg == CNT_W'(POS_SEQ_LO)) seq_next[7:0]  = data_byte;
            if (!odd_reg)
            begin
                high_next = data_byte;
                odd_next  = 1'b1;
            end
            else
            begin
                sum_next  = fold16(18'(sum_reg) + 18'(word));
                rsum_next = fold16(18'(rsum_reg) + 18'(rword));
                odd_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            too_long_reg <= 1'b0;
            sum_reg      <= '0;
            rsum_reg     <= '0;
            odd_reg      <= 1'b0;
            high_reg     <= '0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            too_long_reg <= too_long_next;
            sum_reg      <= sum_next;
            rsum_reg     <= rsum_next;
            odd_reg      <= odd_next;
            high_reg     <= high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        id_reg   <= id_next;
        seq_reg  <= seq_next;
    end

    // odd-length tail counts as a word padded with a zero low byte
    assign tail  = odd_reg ? {high_reg, 8'h00} : 16'h0000;
    assign s_fin = fold16(18'(sum_reg) + 18'(tail));
    assign r_fin = fold16(18'(rsum_reg) + 18'(tail));

    always_comb
    begin
        status.len        = cnt_reg;
        status.too_long   = too_long_reg;
        status.msg_ok     = (cnt_reg >= CNT_W'(MIN_LEN)) && (s_fin == SUM_GOOD);
        status.msg_type   = type_reg;
        status.msg_id     = id_reg;
        status.msg_seq    = seq_reg;
        status.reply_csum = ~r_fin;
    end

endmodule
`default_nettype wire

[hdl/iecho_tx.sv]
// Control and transmit side: message verdict, ping state, tick counter, result beats.
`default_nettype none
module iecho_tx
    import iecho_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [1:0]        req_type,
    input  wire logic              last_byte,
    input  wire logic [31:0]       src_addr,
    input  wire logic [31:0]       ping_dest,
    input  wire logic [15:0]       ping_seq,
    input  wire rx_status_t        rx_stat,
    output logic                   rx_clear,
    output logic                   ready,
    output logic                   rd_en,
    output logic      [ADDR_W-1:0] rd_addr,
    input  wire logic [7:0]        rd_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [1:0]        out_kind,
    output logic      [7:0]        out_byte,
    output logic                   out_last,
    output logic      [31:0]       dest_addr,
    output logic      [LEN_W-1:0]  out_length,
    output logic      [31:0]       round_trip
);

    tx_state_t state_reg, state_next;

    logic [31:0]      tick_reg, tick_next;
    logic [15:0]      exp_id_reg, exp_id_next;
    logic [15:0]      exp_seq_reg, exp_seq_next;
    logic [31:0]      sent_reg, sent_next;

    logic [1:0]       kind_reg, kind_next;
    logic [31:0]      dest_reg, dest_next;
    logic [IDX_W-1:0] len_reg, len_next;
    logic [15:0]      csum_reg, csum_next;
    logic [31:0]      rtt_reg, rtt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    logic             pend_reg, pend_next;

    logic             ov_reg, ov_next;
    logic [1:0]       ok_reg;
    logic [7:0]       ob_reg;
    logic             ol_reg;
    logic [31:0]      od_reg;
    logic [LEN_W-1:0] olen_reg;
    logic [31:0]      ort_reg;

    logic        take_byte_last;
    logic        take_tick;
    logic        take_ping;
    logic        do_reply;
    logic        do_match;
    logic        issue;
    logic        load;
    logic        beat_last;
    logic [15:0] ping_csum;
    logic [7:0]  beat_byte;

    assign take_byte_last = accept && (req_type == REQ_BYTE) && last_byte;
    assign take_tick      = accept && (req_type == REQ_TICK);
    assign take_ping      = accept && (req_type == REQ_PING);

    assign do_reply = rx_stat.msg_ok && (rx_stat.msg_type == TYPE_ECHO_REQ)
                      && !rx_stat.too_long;
    assign do_match = rx_stat.msg_ok && (rx_stat.msg_type == TYPE_ECHO_REPLY)
                      && (rx_stat.msg_id == exp_id_reg) && (rx_stat.msg_seq == exp_seq_reg);

    assign ping_csum = ~fold16(18'(16'h0800) + 18'(tick_reg[15:0]) + 18'(ping_seq)
                               + 18'(PAD_SUM));

    // a read goes out only when the output register will be free for its data
    assign issue     = (state_reg == ST_EMIT) && !pend_reg && (idx_reg < len_reg)
                       && (!ov_reg || out_ready);
    assign load      = pend_reg;
    assign beat_last = ((IDX_W + 1)'(pidx_reg) + (IDX_W + 1)'(1)) == (IDX_W + 1)'(len_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_byte_last)
                    state_next = ST_FINISH;
                else if (take_ping)
                    state_next = ST_EMIT;
            end
            ST_FINISH:
            begin
                if (do_reply || do_match)
                    state_next = ST_EMIT;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (load && beat_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        ready    = 1'b0;
        rx_clear = 1'b0;
        rd_en    = 1'b0;
        case (state_reg)
            ST_IDLE:   ready    = 1'b1;
            ST_FINISH: rx_clear = 1'b1;
            ST_EMIT:   rd_en    = issue && (kind_reg == KIND_REPLY);
            default:   ready    = 1'b0;
        endcase
    end

    assign rd_addr = idx_reg[ADDR_W-1:0];

    // byte of the beat being loaded
    always_comb
    begin
        beat_byte = 8'h00;
        case (kind_reg)
            KIND_REPLY:
            begin
                if (pidx_reg == IDX_W'(POS_TYPE))
                    beat_byte = TYPE_ECHO_REPLY;
                else if (pidx_reg == IDX_W'(POS_CSUM_HI))
                    beat_byte = csum_reg[15:8];
                else if (pidx_reg == IDX_W'(POS_CSUM_LO))
                    beat_byte = csum_reg[7:0];
                else
                    beat_byte = rd_data;
            end
            KIND_REQUEST:
            begin
                if (pidx_reg == IDX_W'(POS_TYPE))
                    beat_byte = TYPE_ECHO_REQ;
                else if (pidx_reg == IDX_W'(POS_CODE))
                    beat_byte = 8'h00;
                else if (pidx_reg == IDX_W'(POS_CSUM_HI))
                    beat_byte = csum_reg[15:8];
                else if (pidx_reg == IDX_W'(POS_CSUM_LO))
                    beat_byte = csum_reg[7:0];
                else if (pidx_reg == IDX_W'(POS_ID_HI))
                    beat_byte = exp_id_reg[15:8];
                else if (pidx_reg == IDX_W'(POS_ID_LO))
                    beat_byte = exp_id_reg[7:0];
                else if (pidx_reg == IDX_W'(POS_SEQ_HI))
                    beat_byte = exp_seq_reg[15:8];
                else if (pidx_reg == IDX_W'(POS_SEQ_LO))
                    beat_byte = exp_seq_reg[7:0];
                else
                    beat_byte = PAD_FILL;
            end
            default:
                beat_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        tick_next    = tick_reg;
        exp_id_next  = exp_id_reg;
        exp_seq_next = exp_seq_reg;
        sent_next    = sent_reg;
        kind_next    = kind_reg;
        dest_next    = dest_reg;
        len_next     = len_reg;
        csum_next    = csum_reg;
        rtt_next     = rtt_reg;
        idx_next     = idx_reg;
        pidx_next    = pidx_reg;
        pend_next    = 1'b0;
        ov_next      = ov_reg && !out_ready;
        if (take_tick)
        begin
            tick_next = tick_reg + 32'd1;
        end
        if (take_byte_last)
        begin
            dest_next = src_addr;
        end
        if (take_ping)
        begin
            exp_id_next  = tick_reg[15:0];
            exp_seq_next = ping_seq;
            sent_next    = tick_reg;
            dest_next    = ping_dest;
            kind_next    = KIND_REQUEST;
            len_next     = IDX_W'(PING_LEN);
            csum_next    = ping_csum;
            idx_next     = '0;
        end
        if (state_reg == ST_FINISH)
        begin
            idx_next = '0;
            if (do_reply)
            begin
                kind_next = KIND_REPLY;
                len_next  = IDX_W'(rx_stat.len);
                csum_next = rx_stat.reply_csum;
            end
            else
            begin
                kind_next = KIND_RTT;
                len_next  = IDX_W'(1);
                rtt_next  = tick_reg - sent_reg;
            end
        end
        if (issue)
        begin
            pend_next = 1'b1;
            pidx_next = idx_reg;
            idx_next  = idx_reg + IDX_W'(1);
        end
        if (load)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            tick_reg    <= '0;
            exp_id_reg  <= '0;
            exp_seq_reg <= '0;
            sent_reg    <= '0;
            pend_reg    <= 1'b0;
            ov_reg      <= 1'b0;
            idx_reg     <= '0;
            len_reg     <= '0;
            kind_reg    <= KIND_REPLY;
        end
        else
        begin
            state_reg   <= state_next;
            tick_reg    <= tick_next;
            exp_id_reg  <= exp_id_next;
            exp_seq_reg <= exp_seq_next;
            sent_reg    <= sent_next;
            pend_reg    <= pend_next;
            ov_reg      <= ov_next;
            idx_reg     <= idx_next;
            len_reg     <= len_next;
            kind_reg    <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg <= dest_next;
        csum_reg <= csum_next;
        rtt_reg  <= rtt_next;
        pidx_reg <= pidx_next;
        if (load)
        begin
            ok_reg <= kind_reg;
            ob_reg <= beat_byte;
            ol_reg <= beat_last;
            if (kind_reg == KIND_RTT)
            begin
                od_reg   <= '0;
                olen_reg <= '0;
                ort_reg  <= rtt_reg;
            end
            else
            begin
                od_reg   <= dest_reg;
                olen_reg <= LEN_W'(len_reg);
                ort_reg  <= '0;
            end
        end
    end

    assign out_valid  = ov_reg;
    assign out_kind   = ok_reg;
    assign out_byte   = ob_reg;
    assign out_last   = ol_reg;
    assign dest_addr  = od_reg;
    assign out_length = olen_reg;
    assign round_trip = ort_reg;

endmodule
`default_nettype wire

[hdl/icmp_echo_responder_top.sv]
// ICMP echo responder: message buffer RAM, receive unit and transmit sequencer.
// Message bytes and ticks are taken one per cycle while the sequencer is idle; the last
// byte of a message passes through a verdict state before the next item is taken.
// Each result beat is a buffer read (replies only), then an output register load.
// Input is held off while the beats of a result go out; the final beat may wait
// in the output register while new input is taken.
// Reset (rst_n low, asynchronous) clears counters, checksums and control; buffer
// contents are not cleared.
`default_nettype none
module icmp_echo_responder_top
    import iecho_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        req_type,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    input  wire logic [31:0]       src_addr,
    input  wire logic [31:0]       ping_dest,
    input  wire logic [15:0]       ping_seq,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [1:0]        out_kind,
    output logic      [7:0]        out_byte,
    output logic                   out_last,
    output logic      [31:0]       dest_addr,
    output logic      [LEN_W-1:0]  out_length,
    output logic      [31:0]       round_trip
);

    logic              accept;
    logic              byte_en;
    logic              rx_clear;
    rx_status_t        rx_stat;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    assign accept  = in_valid && in_ready;
    assign byte_en = accept && (req_type == REQ_BYTE);

    iecho_ram #(
        .WIDTH(8),
        .DEPTH(BUF_BYTES)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    iecho_rx u_rx (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .data_byte (data_byte),
        .clear     (rx_clear),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .status    (rx_stat)
    );

    iecho_tx u_tx (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req_type   (req_type),
        .last_byte  (last_byte),
        .src_addr   (src_addr),
        .ping_dest  (ping_dest),
        .ping_seq   (ping_seq),
        .rx_stat    (rx_stat),
        .rx_clear   (rx_clear),
        .ready      (in_ready),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_kind   (out_kind),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .dest_addr  (dest_addr),
        .out_length (out_length),
        .round_trip (round_trip)
    );

endmodule
`default_nettype wire

[dv/testbench.sv]
// Testbench for the ICMP echo responder: directed table, random message traffic, scoreboard.
module testbench;
    import iecho_pkg::*;

    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam int         ITEMS_TOTAL   = 300;
    localparam int         LONG_HOLD     = 400;
    localparam int         SETTLE_CYCLES = 3 * EMIT_MAX + 20;
    localparam int         CYCLE_LIMIT   = 600000;

    typedef logic [7:0] byte_q_t [$];

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic             last;
        logic [31:0]      dest;
        logic [LEN_W-1:0] len;
        logic [31:0]      rtt;
    } echo_beat_t;

    typedef struct packed {
        logic [1:0]  req;
        logic [7:0]  data;
        logic        last;
        logic [31:0] src;
        logic [31:0] dest;
        logic [15:0] seq;
    } stim_t;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_RTT
    } row_check_t;

    // addr is the source address for message bytes, the destination for a ping
    typedef struct packed {
        logic [1:0]  req;
        logic [7:0]  data;
        logic        last;
        logic [31:0] addr;
        logic [15:0] seq;
        row_check_t  check;
        logic [31:0] rtt;
    } dir_row_t;

    localparam dir_row_t DIRECTED [27] = '{
        // reply with id 0, seq 0 matches the post-reset ping state
        '{REQ_BYTE, TYPE_ECHO_REPLY, 1'b0, 32'h0000_0000, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'h00, 1'b0, 32'h0000_0000, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'hFF, 1'b0, 32'h0000_0000, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'hFF, 1'b0, 32'h0000_0000, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'h00, 1'b0, 32'h0000_0000, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'h00, 1'b0, 32'h0000_0000, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'h00, 1'b0, 32'h0000_0000, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'h00, 1'b1, 32'h0000_0000, 16'h0000, CHK_RTT, 32'd0},
        // ping at tick 0: id 0, seq all ones
        '{REQ_PING, 8'h00, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, CHK_MODEL, 32'd0},
        // matching reply with a tick slipped in before its last byte
        '{REQ_BYTE, TYPE_ECHO_REPLY, 1'b0, 32'h8000_0001, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'h00, 1'b0, 32'h8000_0001, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'h00, 1'b0, 32'h8000_0001, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'h00, 1'b0, 32'h8000_0001, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'h00, 1'b0, 32'h8000_0001, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'h00, 1'b0, 32'h8000_0001, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'hFF, 1'b0, 32'h8000_0001, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_TICK, 8'hFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'hFF, 1'b1, 32'h1234_5678, 16'h0000, CHK_RTT, 32'd1},
        // minimal echo request, unknown request in the middle is dropped
        '{REQ_BYTE, TYPE_ECHO_REQ, 1'b0, 32'h0000_0000, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'h00, 1'b0, 32'h0000_0000, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'hF7, 1'b0, 32'h0000_0000, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'hFF, 1'b0, 32'h0000_0000, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'h00, 1'b0, 32'h0000_0000, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'h00, 1'b0, 32'h0000_0000, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'h00, 1'b0, 32'h0000_0000, 16'h0000, CHK_NONE, 32'd0},
        '{REQ_BYTE, 8'h00, 1'b1, 32'hFFFF_FFFF, 16'h0000, CHK_MODEL, 32'd0}
    };

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic [1:0]        req_type   = REQ_BYTE;
    logic [7:0]        data_byte  = 8'h00;
    logic              last_byte  = 1'b0;
    logic [31:0]       src_addr   = 32'h0;
    logic [31:0]       ping_dest  = 32'h0;
    logic [15:0]       ping_seq   = 16'h0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic [1:0]        out_kind;
    logic [7:0]        out_byte;
    logic              out_last;
    logic [31:0]       dest_addr;
    logic [LEN_W-1:0]  out_length;
    logic [31:0]       round_trip;

    // predictor state
    logic [7:0]  rx_buf [BUF_BYTES];
    int          rx_count  = 0;
    bit          rx_long   = 1'b0;
    logic [15:0] rx_sum    = '0;
    logic [7:0]  rx_hi     = '0;
    bit          rx_odd    = 1'b0;
    logic [15:0] ping_id   = '0;
    logic [15:0] ping_sq   = '0;
    logic [31:0] ping_time = '0;
    logic [31:0] ticks     = '0;
    logic [31:0] rtt_last  = '0;

    echo_beat_t  model_beats [$];
    echo_beat_t  awaited_beats [$];
    int          error_count = 0;
    int          beat_count  = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    bit          hold_req    = 1'b0;
    int unsigned cycle_count = 0;

    icmp_echo_responder_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .src_addr   (src_addr),
        .ping_dest  (ping_dest),
        .ping_seq   (ping_seq),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_kind   (out_kind),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .dest_addr  (dest_addr),
        .out_length (out_length),
        .round_trip (round_trip)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [15:0] ones_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, w};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    // ones-complement sum, odd trailing byte padded low
    function automatic logic [15:0] ones_sum(input byte_q_t b);
        logic [15:0] s;
        logic [7:0]  lo;
        s = '0;
        for (int i = 0; i < b.size(); i += 2)
        begin
            lo = (i + 1 < b.size()) ? b[i + 1] : 8'h00;
            s = ones_add(s, {b[i], lo});
        end
        return s;
    endfunction

    task automatic echo_predict(input stim_t s);
        byte_q_t     pkt;
        logic [15:0] sum;
        logic [15:0] csum;
        logic [15:0] id;
        begin
            model_beats.delete();
            case (s.req)
                REQ_BYTE:
                begin
                    if (rx_count < BUF_BYTES)
                    begin
                        rx_buf[rx_count] = s.data;
                        rx_count++;
                    end
                    else
                    begin
                        rx_long  = 1'b1;
                        rx_count = BUF_BYTES + 1;
                    end
                    if (!rx_odd)
                    begin
                        rx_hi  = s.data;
                        rx_odd = 1'b1;
                    end
                    else
                    begin
                        rx_sum = ones_add(rx_sum, {rx_hi, s.data});
                        rx_odd = 1'b0;
                    end
                    if (s.last)
                    begin
                        sum = rx_sum;
                        if (rx_odd)
                            sum = ones_add(sum, {rx_hi, 8'h00});
                        if (rx_count >= MIN_LEN && sum == SUM_GOOD)
                        begin
                            if (rx_buf[POS_TYPE] == TYPE_ECHO_REQ)
                            begin
                                if (!rx_long)
                                begin
                                    for (int i = 0; i < rx_count; i++)
                                        pkt.push_back(rx_buf[i]);
                                    pkt[POS_TYPE]    = TYPE_ECHO_REPLY;
                                    pkt[POS_CSUM_HI] = 8'h00;
                                    pkt[POS_CSUM_LO] = 8'h00;
                                    csum = ~ones_sum(pkt);
                                    pkt[POS_CSUM_HI] = csum[15:8];
                                    pkt[POS_CSUM_LO] = csum[7:0];
                                    foreach (pkt[i])
                                        model_beats.push_back(echo_beat_t'{KIND_REPLY, pkt[i],
                                            i == pkt.size() - 1, s.src, LEN_W'(rx_count), 32'd0});
                                end
                            end
                            else if (rx_buf[POS_TYPE] == TYPE_ECHO_REPLY
                                     && {rx_buf[POS_ID_HI], rx_buf[POS_ID_LO]} == ping_id
                                     && {rx_buf[POS_SEQ_HI], rx_buf[POS_SEQ_LO]} == ping_sq)
                            begin
                                rtt_last = ticks - ping_time;
                                model_beats.push_back(echo_beat_t'{KIND_RTT, 8'h00, 1'b1,
                                    32'd0, LEN_W'(0), rtt_last});
                            end
                        end
                        rx_count = 0;
                        rx_long  = 1'b0;
                        rx_sum   = '0;
                        rx_hi    = '0;
                        rx_odd   = 1'b0;
                    end
                end
                REQ_TICK:
                    ticks++;
                REQ_PING:
                begin
                    id        = ticks[15:0];
                    ping_id   = id;
                    ping_sq   = s.seq;
                    ping_time = ticks;
                    rtt_last  = '0;
                    pkt = {TYPE_ECHO_REQ, 8'h00, 8'h00, 8'h00, id[15:8], id[7:0],
                           s.seq[15:8], s.seq[7:0]};
                    repeat (PAD_BYTES) pkt.push_back(PAD_FILL);
                    csum = ~ones_sum(pkt);
                    pkt[POS_CSUM_HI] = csum[15:8];
                    pkt[POS_CSUM_LO] = csum[7:0];
                    foreach (pkt[i])
                        model_beats.push_back(echo_beat_t'{KIND_REQUEST, pkt[i],
                            i == pkt.size() - 1, s.dest, LEN_W'(PING_LEN), 32'd0});
                end
                default:
                    ;
            endcase
        end
    endtask

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        if (error_count < 50)
            $display("[%0t] beat %0d: %s got %h want %h", $time, beat_count, field, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (awaited_beats.size() == 0)
                report("unexpected beat, byte", 32'(out_byte), 32'd0);
            else
            begin
                if (out_kind !== awaited_beats[0].kind)
                    report("kind", 32'(out_kind), 32'(awaited_beats[0].kind));
                if (out_byte !== awaited_beats[0].data)
                    report("byte", 32'(out_byte), 32'(awaited_beats[0].data));
                if (out_last !== awaited_beats[0].last)
                    report("last", 32'(out_last), 32'(awaited_beats[0].last));
                if (dest_addr !== awaited_beats[0].dest)
                    report("dest", dest_addr, awaited_beats[0].dest);
                if (out_length !== awaited_beats[0].len)
                    report("length", 32'(out_length), 32'(awaited_beats[0].len));
                if (round_trip !== awaited_beats[0].rtt)
                    report("round_trip", round_trip, awaited_beats[0].rtt);
                void'(awaited_beats.pop_front());
            end
            beat_count++;
        end
    end

    // receiver: changes stall style at random intervals, plus one long hold on request
    initial
    begin
        int hold_left;
        int mode_left;
        int rx_mode;
        int phase;
        hold_left = 0;
        mode_left = 0;
        rx_mode   = 0;
        phase     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                phase++;
                case (rx_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (phase % 7) < 4;
                endcase
            end
        end
    end

    function automatic stim_t rand_stim(input logic [1:0] req);
        stim_t s;
        s.req  = req;
        s.data = 8'($urandom);
        s.last = 1'($urandom);
        s.src  = $urandom;
        s.dest = $urandom;
        s.seq  = 16'($urandom);
        return s;
    endfunction

    // well-formed header with a valid checksum over all len bytes
    function automatic byte_q_t echo_msg(input logic [7:0] mtype, input logic [15:0] id,
                                         input logic [15:0] sq, input int len);
        byte_q_t     q;
        logic [15:0] csum;
        q = {mtype, 8'($urandom), 8'h00, 8'h00, id[15:8], id[7:0], sq[15:8], sq[7:0]};
        while (q.size() < len)
            q.push_back(8'($urandom));
        csum = ~ones_sum(q);
        q[POS_CSUM_HI] = csum[15:8];
        q[POS_CSUM_LO] = csum[7:0];
        return q;
    endfunction

    task automatic send_item(input stim_t s, input bit use_model);
        int gap;
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            in_valid  <= 1'b1;
            req_type  <= s.req;
            data_byte <= s.data;
            last_byte <= s.last;
            src_addr  <= s.src;
            ping_dest <= s.dest;
            ping_seq  <= s.seq;
            do
                @(posedge clk);
            while (in_ready !== 1'b1);
            echo_predict(s);
            if (use_model)
                foreach (model_beats[i])
                    awaited_beats.push_back(model_beats[i]);
            if (s.req != REQ_UNUSED)
                items_sent++;
        end
    endtask

    // message bytes, with the odd tick, ping or unknown request slipped in between
    task automatic send_message(input byte_q_t q);
        stim_t s;
        logic [1:0] side_req;
        begin
            foreach (q[i])
            begin
                if ($urandom_range(0, 24) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: side_req = REQ_TICK;
                        1: side_req = REQ_PING;
                        default: side_req = REQ_UNUSED;
                    endcase
                    send_item(rand_stim(side_req), 1'b1);
                end
                s      = rand_stim(REQ_BYTE);
                s.data = q[i];
                s.last = (i == q.size() - 1);
                send_item(s, 1'b1);
            end
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (awaited_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    initial
    begin
        stim_t    s;
        dir_row_t row;
        byte_q_t  msg;
        int       pick;
        int       len;
        bit       hold_done;
        bit       pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[r])
        begin
            row    = DIRECTED[r];
            s.req  = row.req;
            s.data = row.data;
            s.last = row.last;
            s.src  = row.addr;
            s.dest = row.addr;
            s.seq  = row.seq;
            send_item(s, row.check == CHK_MODEL);
            if (row.check == CHK_RTT)
                awaited_beats.push_back(echo_beat_t'{KIND_RTT, 8'h00, 1'b1, 32'd0,
                                                     LEN_W'(0), row.rtt});
        end
        settle();

        while (items_sent < ITEMS_TOTAL)
        begin
            if (!hold_done && items_sent >= 120)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && items_sent >= 240)
            begin
                settle();
                pause_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                len = $urandom_range(MIN_LEN, 20);
                if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(21, BUF_BYTES);
                if ($urandom_range(0, 15) == 0)
                    len = BUF_BYTES;
                send_message(echo_msg(TYPE_ECHO_REQ, 16'($urandom), 16'($urandom), len));
            end
            else if (pick < 42)
            begin
                // reply to the outstanding ping, sometimes past the buffer size
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(BUF_BYTES + 1, BUF_BYTES + 8)
                                                  : $urandom_range(MIN_LEN, 16);
                send_message(echo_msg(TYPE_ECHO_REPLY, ping_id, ping_sq, len));
            end
            else if (pick < 50)
                send_item(rand_stim(REQ_PING), 1'b1);
            else if (pick < 57)
                repeat ($urandom_range(1, 5)) send_item(rand_stim(REQ_TICK), 1'b1);
            else if (pick < 63)
                send_message(echo_msg(TYPE_ECHO_REPLY, 16'($urandom), 16'($urandom),
                                      $urandom_range(MIN_LEN, 16)));
            else if (pick < 69)
                send_message(echo_msg(8'($urandom_range(1, 7)), 16'($urandom), 16'($urandom),
                                      $urandom_range(MIN_LEN, 16)));
            else if (pick < 75)
            begin
                msg = echo_msg(($urandom_range(0, 1) == 0) ? TYPE_ECHO_REQ : TYPE_ECHO_REPLY,
                               ping_id, ping_sq, $urandom_range(MIN_LEN, 16));
                pick = $urandom_range(0, msg.size() - 1);
                msg[pick] = msg[pick] ^ (8'd1 << $urandom_range(0, 7));
                send_message(msg);
            end
            else if (pick < 81)
            begin
                // runt message
                msg = {};
                len = $urandom_range(1, MIN_LEN - 1);
                repeat (len) msg.push_back(8'($urandom));
                if ($urandom_range(0, 1) == 0)
                    msg[POS_TYPE] = TYPE_ECHO_REQ;
                send_message(msg);
            end
            else if (pick < 86)
                send_message(echo_msg(TYPE_ECHO_REQ, 16'($urandom), 16'($urandom),
                                      $urandom_range(BUF_BYTES + 1, BUF_BYTES + 6)));
            else if (pick < 91)
                send_item(rand_stim(REQ_UNUSED), 1'b1);
            else
                send_item(rand_stim(2'($urandom)), 1'b1);
        end

        settle();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[icmp_echo_responder_top.f]
hdl/iecho_pkg.sv
hdl/iecho_ram.sv
hdl/iecho_rx.sv
hdl/iecho_tx.sv
hdl/icmp_echo_responder_top.sv
dv/testbench.sv
